// ----- sv/adsr_pkg.sv -----
package adsr_pkg;

    localparam int MAX_ECHOES_DEF = 16;

    localparam int DIVD_W = 26;
    localparam int DIVS_W = 18;
    localparam int POS_W  = 18;
    localparam int PCT_W  = 7;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [POS_W-1:0] TICK_MAX      = 18'h3FFFF;
    localparam logic [15:0]      LFSR_SEED     = 16'hACE1;
    localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;
    localparam logic [8:0]       ENV_ONE       = 9'd256;

    // register map, index = byte address / 4
    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_DECAY   = 3'd1;
    localparam logic [2:0] REG_SUSTAIN = 3'd2;
    localparam logic [2:0] REG_RELEASE = 3'd3;
    localparam logic [2:0] REG_REVERB  = 3'd4;
    localparam logic [2:0] REG_NOISE   = 3'd5;
    localparam logic [2:0] REG_DISTORT = 3'd6;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quot;
        logic [DIVS_W-1:0] rem;
    } div_rsp_t;

    // sustain percent to 1.8: (pct * 256) / 100 by reciprocal, exact for pct <= 100
    function automatic logic [8:0] sustain_8p8(input logic [PCT_W-1:0] pct);
        logic [PCT_W-1:0] p;
        logic [19:0]      t;
        p = (pct > PCT_FULL) ? PCT_FULL : pct;
        t = 20'(p) * 20'd5243;
        return t[19:11];
    endfunction

endpackage

// ----- sv/adsr_ram.sv -----
module adsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/adsr_div.sv -----
module adsr_div (
    input  logic                clk,
    input  logic                rst_n,
    input  adsr_pkg::div_req_t  req,
    output adsr_pkg::div_rsp_t  rsp
);

    localparam int CNT_W = $clog2(adsr_pkg::DIVD_W + 1);

    logic [adsr_pkg::DIVD_W-1:0] quo_reg;
    logic [adsr_pkg::DIVS_W-1:0] rem_reg;
    logic [adsr_pkg::DIVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        done_reg;

    logic [adsr_pkg::DIVS_W:0]   shifted;
    logic                        fits;
    logic [adsr_pkg::DIVS_W-1:0] rem_next;

    // one quotient bit a cycle, restoring
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[adsr_pkg::DIVD_W-1]};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? adsr_pkg::DIVS_W'(shifted - {1'b0, dvs_reg})
                        : shifted[adsr_pkg::DIVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            quo_reg  <= req.dividend;
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
            cnt_reg  <= CNT_W'(adsr_pkg::DIVD_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[adsr_pkg::DIVD_W-2:0], fits};
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- sv/adsr_voice_envelope_generator.sv -----
// ADSR voice envelope generator, one input word per millisecond.
// Input channel (in_valid/in_stall): action 0 loads a note (frequency,
// duration, volume, bend), clears the ms counter and produces no result.
// Action 1 is a tick: it produces one output word (bent frequency, level,
// active, position) and then advances the saturating counter.
// A tick is worked on by a small sequencer around one shared 26/18-bit
// restoring divider and one 19x19 multiplier. Each evaluated echo level
// takes up to three divisions forward and two backward; in_stall is high
// for the whole tick.
// Configuration must be written over the APB port only while the block is
// idle; the block itself does not enforce this.
// Per-level echo times and levels sit in a small RAM.
// The output word sits in a register: a new word may be accepted while it
// waits, but the next result is held until out_stall drops.
// Reset clears the configuration (sustain 100 %), the note (volume 100 %),
// the counter and seeds the noise LFSR; no clearing pass is needed.
module adsr_voice_envelope_generator #(
    parameter int MAX_ECHOES = adsr_pkg::MAX_ECHOES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [15:0]                   note_frequency,
    input  logic [15:0]                   note_duration,
    input  logic [adsr_pkg::PCT_W-1:0]    note_volume,
    input  logic signed [15:0]            bend_step,
    input  logic [15:0]                   bend_interval,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [15:0]                   tone_frequency,
    output logic [adsr_pkg::PCT_W-1:0]    level,
    output logic                          active,
    output logic [adsr_pkg::POS_W-1:0]    position,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adsr_pkg::ADDR_W-1:0]   paddr,
    input  logic [adsr_pkg::DATA_W-1:0]   pwdata,
    output logic [adsr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int IDX_W = (MAX_ECHOES > 1) ? $clog2(MAX_ECHOES) : 1;
    localparam int POS_W = adsr_pkg::POS_W;
    localparam int PCT_W = adsr_pkg::PCT_W;
    localparam int ECHO_W = POS_W + PCT_W;
    localparam logic [8:0] ENV_ONE_W = adsr_pkg::ENV_ONE;

    typedef enum logic [4:0] {
        S_IDLE, S_BEND, S_BEND_DIV, S_BEND_MUL, S_BEND_SAT, S_FULL,
        S_QUANT, S_QUANT_DIV, S_ENV, S_E_DIV, S_E_MUL, S_E_FIN,
        S_VOL, S_VOL_FIN, S_NOISE_DIV, S_STORE,
        S_RD, S_BL, S_BM, S_B1, S_B1W, S_B2, S_B3, S_B3W, S_NEXT, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        RGN_ATT, RGN_DEC, RGN_SUS, RGN_REL, RGN_OFF
    } rgn_t;

    state_t state_reg;

    // configuration
    logic [15:0]      attack_reg, decay_reg, release_reg, reverb_reg, distort_reg;
    logic [PCT_W-1:0] sustain_reg;
    logic [7:0]       noise_reg;

    // note
    logic [POS_W-1:0] tick_reg;
    logic [15:0]      start_freq_reg, bent_freq_reg, duration_reg, period_reg;
    logic [PCT_W-1:0] volume_reg;
    logic [15:0]      bend_reg;
    logic [15:0]      lfsr_reg;

    // working registers
    logic [POS_W-1:0]         full_reg, m_reg, q_reg;
    logic [IDX_W-1:0]         k_reg;
    logic                     first_reg, last_blend_reg;
    logic [PCT_W-1:0]         lvl_reg, acc_reg, t1_reg;
    logic [8:0]               e_reg;
    rgn_t                     rgn_reg;
    logic signed [37:0]       prod_reg;

    // output word
    logic                     out_valid_reg;
    logic [15:0]              freq_out_reg;
    logic [PCT_W-1:0]         level_out_reg;
    logic                     active_out_reg;
    logic [POS_W-1:0]         pos_out_reg;

    adsr_pkg::div_req_t       div_req;
    adsr_pkg::div_rsp_t       div_rsp;

    logic signed [18:0]       mul_a, mul_b;
    logic [8:0]               s8;
    rgn_t                     rgn;
    logic [15:0]              min_da;
    logic [POS_W-1:0]         min_dad;
    logic [15:0]              lfsr_next;
    logic signed [10:0]       noise_t;
    logic signed [38:0]       fsum;
    logic                     blend;
    logic                     echo_we;
    logic [ECHO_W-1:0]        echo_rdata;
    logic                     in_take;

    assign in_take  = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign pready   = 1'b1;

    assign s8        = adsr_pkg::sustain_8p8(sustain_reg);
    assign lfsr_next = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                        lfsr_reg[15:1]};
    assign blend     = (reverb_reg != '0) && (m_reg > POS_W'(reverb_reg));
    assign echo_we   = (state_reg == S_STORE);

    assign noise_t = $signed({4'd0, lvl_reg}) + $signed({3'd0, div_rsp.rem[7:0]})
                   - $signed({4'd0, noise_reg[7:1]});
    assign fsum    = $signed({23'd0, start_freq_reg}) + $signed({prod_reg[37], prod_reg});

    // envelope phase of the quantised ms
    always_comb
    begin
        min_da  = (duration_reg < attack_reg) ? duration_reg : attack_reg;
        min_dad = (POS_W'(duration_reg) < POS_W'(attack_reg) + POS_W'(decay_reg))
                ? POS_W'(duration_reg) : POS_W'(attack_reg) + POS_W'(decay_reg);
        priority if (m_reg < POS_W'(min_da))
            rgn = RGN_ATT;
        else if (m_reg < min_dad)
            rgn = RGN_DEC;
        else if (m_reg < POS_W'(duration_reg))
            rgn = RGN_SUS;
        else if (m_reg < POS_W'(duration_reg) + POS_W'(release_reg))
            rgn = RGN_REL;
        else
            rgn = RGN_OFF;
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_BEND_MUL:
            begin
                mul_a = {{3{bend_reg[15]}}, bend_reg};
                mul_b = {1'b0, q_reg};
            end
            S_E_MUL:
            begin
                if (rgn_reg == RGN_DEC)
                begin
                    mul_a = {1'b0, q_reg};
                    mul_b = 19'(ENV_ONE_W - s8);
                end
                else
                begin
                    mul_a = 19'(ENV_ONE_W - 9'(q_reg));
                    mul_b = 19'(s8);
                end
            end
            S_VOL:
            begin
                mul_a = 19'(volume_reg);
                mul_b = 19'(e_reg);
            end
            S_BM:
            begin
                mul_a = 19'(lvl_reg);
                mul_b = {1'b0, q_reg};
            end
            S_B2:
            begin
                mul_a = 19'(acc_reg);
                mul_b = {1'b0, full_reg - q_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared divider requests
    always_comb
    begin
        div_req = '0;
        unique case (state_reg)
            S_BEND:
            begin
                div_req.start    = (bend_reg != '0) && (period_reg != '0);
                div_req.dividend = adsr_pkg::DIVD_W'(tick_reg);
                div_req.divisor  = adsr_pkg::DIVS_W'(period_reg);
            end
            S_QUANT:
            begin
                div_req.start    = (distort_reg != '0);
                div_req.dividend = adsr_pkg::DIVD_W'(m_reg);
                div_req.divisor  = adsr_pkg::DIVS_W'(distort_reg);
            end
            S_ENV:
            begin
                div_req.start = (rgn == RGN_ATT) || (rgn == RGN_DEC) || (rgn == RGN_REL);
                unique case (rgn)
                    RGN_ATT:
                    begin
                        div_req.dividend = {m_reg, 8'd0};
                        div_req.divisor  = adsr_pkg::DIVS_W'(attack_reg);
                    end
                    RGN_DEC:
                    begin
                        div_req.dividend = {m_reg - POS_W'(attack_reg), 8'd0};
                        div_req.divisor  = adsr_pkg::DIVS_W'(decay_reg);
                    end
                    default:
                    begin
                        div_req.dividend = {m_reg - POS_W'(duration_reg), 8'd0};
                        div_req.divisor  = adsr_pkg::DIVS_W'(release_reg);
                    end
                endcase
            end
            S_VOL_FIN:
            begin
                div_req.start    = (noise_reg != '0);
                div_req.dividend = adsr_pkg::DIVD_W'(lfsr_next);
                div_req.divisor  = adsr_pkg::DIVS_W'(noise_reg);
            end
            S_B1, S_B3:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg[adsr_pkg::DIVD_W-1:0];
                div_req.divisor  = full_reg;
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    adsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    adsr_ram #(
        .WIDTH (ECHO_W),
        .DEPTH (MAX_ECHOES)
    ) u_echo (
        .clk   (clk),
        .we    (echo_we),
        .waddr (k_reg),
        .wdata ({m_reg, lvl_reg}),
        .raddr (k_reg),
        .rdata (echo_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            attack_reg     <= '0;
            decay_reg      <= '0;
            sustain_reg    <= adsr_pkg::PCT_FULL;
            release_reg    <= '0;
            reverb_reg     <= '0;
            noise_reg      <= '0;
            distort_reg    <= '0;
            tick_reg       <= '0;
            start_freq_reg <= '0;
            bent_freq_reg  <= '0;
            duration_reg   <= '0;
            volume_reg     <= adsr_pkg::PCT_FULL;
            bend_reg       <= '0;
            period_reg     <= '0;
            lfsr_reg       <= adsr_pkg::LFSR_SEED;
            out_valid_reg  <= 1'b0;
            k_reg          <= '0;
            first_reg      <= 1'b0;
            last_blend_reg <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;

            if (psel && penable && pwrite)
            begin
                unique case (paddr[4:2])
                    adsr_pkg::REG_ATTACK:  attack_reg  <= pwdata[15:0];
                    adsr_pkg::REG_DECAY:   decay_reg   <= pwdata[15:0];
                    adsr_pkg::REG_SUSTAIN: sustain_reg <= pwdata[PCT_W-1:0];
                    adsr_pkg::REG_RELEASE: release_reg <= pwdata[15:0];
                    adsr_pkg::REG_REVERB:  reverb_reg  <= pwdata[15:0];
                    adsr_pkg::REG_NOISE:   noise_reg   <= pwdata[7:0];
                    adsr_pkg::REG_DISTORT: distort_reg <= pwdata[15:0];
                    default: ;
                endcase
            end

            // drop the word once taken, unless a new one replaces it
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take && !action)
                    begin
                        start_freq_reg <= note_frequency;
                        bent_freq_reg  <= note_frequency;
                        duration_reg   <= note_duration;
                        volume_reg     <= (note_volume > adsr_pkg::PCT_FULL)
                                        ? adsr_pkg::PCT_FULL : note_volume;
                        bend_reg       <= bend_step;
                        period_reg     <= bend_interval;
                        tick_reg       <= '0;
                    end
                    else if (in_take)
                    begin
                        state_reg <= S_BEND;
                    end
                end
                S_BEND:
                begin
                    full_reg  <= POS_W'(duration_reg) + POS_W'(release_reg)
                               + POS_W'(reverb_reg);
                    state_reg <= div_req.start ? S_BEND_DIV : S_FULL;
                end
                S_BEND_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        q_reg     <= div_rsp.quot[POS_W-1:0];
                        state_reg <= S_BEND_MUL;
                    end
                end
                S_BEND_MUL:
                begin
                    state_reg <= S_BEND_SAT;
                end
                S_BEND_SAT:
                begin
                    if (fsum[38])
                        bent_freq_reg <= '0;
                    else if (fsum > 39'sd65535)
                        bent_freq_reg <= 16'hFFFF;
                    else
                        bent_freq_reg <= fsum[15:0];
                    state_reg <= S_FULL;
                end
                S_FULL:
                begin
                    acc_reg   <= '0;
                    k_reg     <= '0;
                    first_reg <= 1'b1;
                    m_reg     <= tick_reg;
                    state_reg <= (tick_reg >= full_reg) ? S_OUT : S_QUANT;
                end
                S_QUANT:
                begin
                    state_reg <= div_req.start ? S_QUANT_DIV : S_ENV;
                end
                S_QUANT_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        m_reg     <= m_reg - div_rsp.rem;
                        state_reg <= S_ENV;
                    end
                end
                S_ENV:
                begin
                    rgn_reg <= rgn;
                    unique case (rgn)
                        RGN_SUS:
                        begin
                            e_reg     <= s8;
                            state_reg <= S_VOL;
                        end
                        RGN_OFF:
                        begin
                            e_reg     <= '0;
                            state_reg <= S_VOL;
                        end
                        default:
                        begin
                            state_reg <= S_E_DIV;
                        end
                    endcase
                end
                S_E_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        q_reg <= div_rsp.quot[POS_W-1:0];
                        if (rgn_reg == RGN_ATT)
                        begin
                            e_reg     <= div_rsp.quot[8:0];
                            state_reg <= S_VOL;
                        end
                        else
                        begin
                            state_reg <= S_E_MUL;
                        end
                    end
                end
                S_E_MUL:
                begin
                    state_reg <= S_E_FIN;
                end
                S_E_FIN:
                begin
                    if (rgn_reg == RGN_DEC)
                        e_reg <= ENV_ONE_W - prod_reg[16:8];
                    else
                        e_reg <= prod_reg[16:8];
                    state_reg <= S_VOL;
                end
                S_VOL:
                begin
                    state_reg <= S_VOL_FIN;
                end
                S_VOL_FIN:
                begin
                    lvl_reg <= prod_reg[14:8];
                    if (noise_reg != '0)
                    begin
                        lfsr_reg  <= lfsr_next;
                        state_reg <= S_NOISE_DIV;
                    end
                    else
                    begin
                        state_reg <= S_STORE;
                    end
                end
                S_NOISE_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (noise_t < 0)
                            lvl_reg <= '0;
                        else if (noise_t > 11'sd100)
                            lvl_reg <= adsr_pkg::PCT_FULL;
                        else
                            lvl_reg <= noise_t[PCT_W-1:0];
                        state_reg <= S_STORE;
                    end
                end
                S_STORE:
                begin
                    // stop at the first level with no echo, or at the depth limit
                    if (!blend || (k_reg == IDX_W'(MAX_ECHOES - 1)))
                    begin
                        last_blend_reg <= blend;
                        state_reg      <= S_RD;
                    end
                    else
                    begin
                        m_reg     <= m_reg - POS_W'(reverb_reg);
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_QUANT;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_BL;
                end
                S_BL:
                begin
                    lvl_reg <= echo_rdata[PCT_W-1:0];
                    q_reg   <= echo_rdata[ECHO_W-1:PCT_W];
                    if (first_reg && !last_blend_reg)
                    begin
                        acc_reg   <= echo_rdata[PCT_W-1:0];
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        state_reg <= S_BM;
                    end
                end
                S_BM:
                begin
                    state_reg <= S_B1;
                end
                S_B1:
                begin
                    state_reg <= S_B1W;
                end
                S_B1W:
                begin
                    if (div_rsp.done)
                    begin
                        t1_reg    <= div_rsp.quot[PCT_W-1:0];
                        state_reg <= S_B2;
                    end
                end
                S_B2:
                begin
                    state_reg <= S_B3;
                end
                S_B3:
                begin
                    state_reg <= S_B3W;
                end
                S_B3W:
                begin
                    if (div_rsp.done)
                    begin
                        acc_reg   <= t1_reg + div_rsp.quot[PCT_W-1:0];
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    first_reg <= 1'b0;
                    if (k_reg == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        k_reg     <= k_reg - 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_OUT:
                begin
                    // hold until the previous word has gone
                    if (!(out_valid_reg && out_stall))
                    begin
                        out_valid_reg  <= 1'b1;
                        freq_out_reg   <= bent_freq_reg;
                        level_out_reg  <= acc_reg;
                        active_out_reg <= (tick_reg <= full_reg);
                        pos_out_reg    <= tick_reg;
                        if (tick_reg < adsr_pkg::TICK_MAX)
                            tick_reg <= tick_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            adsr_pkg::REG_ATTACK:  prdata = adsr_pkg::DATA_W'(attack_reg);
            adsr_pkg::REG_DECAY:   prdata = adsr_pkg::DATA_W'(decay_reg);
            adsr_pkg::REG_SUSTAIN: prdata = adsr_pkg::DATA_W'(sustain_reg);
            adsr_pkg::REG_RELEASE: prdata = adsr_pkg::DATA_W'(release_reg);
            adsr_pkg::REG_REVERB:  prdata = adsr_pkg::DATA_W'(reverb_reg);
            adsr_pkg::REG_NOISE:   prdata = adsr_pkg::DATA_W'(noise_reg);
            adsr_pkg::REG_DISTORT: prdata = adsr_pkg::DATA_W'(distort_reg);
            default:               prdata = '0;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign tone_frequency = freq_out_reg;
    assign level          = level_out_reg;
    assign active         = active_out_reg;
    assign position       = pos_out_reg;

endmodule

// ----- sv/adsr_checker.sv -----
module adsr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        action,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [adsr_pkg::PCT_W-1:0]  level,
    input logic                        active
);

    // a tick keeps the block busy on the next cycle
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action |=> in_stall)
        else $error("tick accepted but input not stalled");

    // a note load completes at once
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !action |=> !in_stall)
        else $error("note load left the block busy");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> level <= adsr_pkg::PCT_FULL)
        else $error("level above full scale");

    a_level_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && level != '0 |-> active)
        else $error("sounding level outside the note");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(level))
        else $error("stalled output word changed");

endmodule

bind adsr_voice_envelope_generator adsr_checker u_adsr_checker (.*);

// ----- bench/adsr_voice_envelope_generator_tb.sv -----
module adsr_voice_envelope_generator_tb;

    localparam int ECHO_DEPTH = adsr_pkg::MAX_ECHOES_DEF;
    localparam int DRAIN_CYCLES = 3000;
    localparam int HOLD_CYCLES = 6000;

    typedef struct packed {
        logic        action;
        logic [15:0] freq;
        logic [15:0] dur;
        logic [6:0]  vol;
        logic [15:0] bend;
        logic [15:0] intv;
    } note_word_t;

    typedef struct packed {
        logic [15:0]                freq;
        logic [6:0]                 lvl;
        logic                       act;
        logic [adsr_pkg::POS_W-1:0] pos;
    } tone_word_t;

    typedef struct {
        note_word_t w;
        bit         typed;
        tone_word_t want;
    } script_row_t;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic action;
    logic [15:0] note_frequency;
    logic [15:0] note_duration;
    logic [adsr_pkg::PCT_W-1:0] note_volume;
    logic signed [15:0] bend_step;
    logic [15:0] bend_interval;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [15:0] tone_frequency;
    logic [adsr_pkg::PCT_W-1:0] level;
    logic active;
    logic [adsr_pkg::POS_W-1:0] position;
    logic psel;
    logic penable;
    logic pwrite;
    logic [adsr_pkg::ADDR_W-1:0] paddr;
    logic [adsr_pkg::DATA_W-1:0] pwdata;
    logic [adsr_pkg::DATA_W-1:0] prdata;
    logic pready;

    adsr_voice_envelope_generator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .action(action),
        .note_frequency(note_frequency), .note_duration(note_duration),
        .note_volume(note_volume), .bend_step(bend_step),
        .bend_interval(bend_interval),
        .out_valid(out_valid), .out_stall(out_stall),
        .tone_frequency(tone_frequency), .level(level), .active(active),
        .position(position),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // envelope model state
    int unsigned env_attack, env_decay, env_sustain, env_release;
    int unsigned env_reverb, env_noise, env_distort;
    int unsigned ms_count, note_start_f, note_bent_f, note_dur, note_vol, note_period;
    int          note_bend;
    logic [15:0] noise_reg;

    tone_word_t tone_q[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("adsr_voice_envelope_generator test failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int unsigned noise_draw();
        logic b;
        b = noise_reg[0] ^ noise_reg[2] ^ noise_reg[3] ^ noise_reg[5];
        noise_reg = {b, noise_reg[15:1]};
        return noise_reg;
    endfunction

    function automatic int unsigned note_level(input int unsigned m);
        int unsigned sus, s8, e, q, lvl;
        int t;
        sus = env_sustain > 100 ? 100 : env_sustain;
        s8 = (sus << 8) / 100;
        e = 0;
        if (m < (note_dur < env_attack ? note_dur : env_attack))
            e = (m << 8) / env_attack;
        else if (m < (note_dur < env_attack + env_decay ? note_dur : env_attack + env_decay))
            e = 256 - (((((m - env_attack) << 8) / env_decay) * (256 - s8)) >> 8);
        else if (m < note_dur)
            e = s8;
        else if (m < note_dur + env_release)
        begin
            q = ((m - note_dur) << 8) / env_release;
            e = ((256 - q) * s8) >> 8;
        end
        lvl = (note_vol * e) >> 8;
        if (env_noise != 0)
        begin
            t = int'(lvl) + int'(noise_draw() % env_noise) - int'(env_noise / 2);
            lvl = t < 0 ? 0 : (t > 100 ? 100 : t);
        end
        return lvl;
    endfunction

    // walk the echo chain outward, then fold it back in
    function automatic int unsigned blended_level(input int unsigned m0);
        int unsigned span, m, acc;
        int unsigned lv[ECHO_DEPTH];
        int unsigned at[ECHO_DEPTH];
        bit mix[ECHO_DEPTH];
        int k, n;
        span = note_dur + env_release + env_reverb;
        if (m0 >= span)
            return 0;
        m = m0;
        n = 0;
        acc = 0;
        for (k = 0; k < ECHO_DEPTH; k++)
        begin
            if (env_distort != 0)
                m -= m % env_distort;
            at[k] = m;
            lv[k] = note_level(m);
            mix[k] = env_reverb != 0 && m > env_reverb;
            n = k + 1;
            if (!mix[k])
                break;
            m -= env_reverb;
        end
        for (k = n - 1; k >= 0; k--)
        begin
            if (mix[k])
                acc = (lv[k] * at[k]) / span + (acc * (span - at[k])) / span;
            else
                acc = lv[k];
        end
        return acc;
    endfunction

    function automatic bit play_word(input note_word_t w, output tone_word_t t);
        longint f;
        int unsigned span;
        t = '0;
        if (w.action == ACT_START)
        begin
            note_start_f = w.freq;
            note_bent_f = w.freq;
            note_dur = w.dur;
            note_vol = w.vol > 100 ? 100 : w.vol;
            note_bend = $signed(w.bend);
            note_period = w.intv;
            ms_count = 0;
            return 1'b0;
        end
        if (note_bend != 0 && note_period != 0)
        begin
            f = longint'(note_start_f) + longint'(note_bend) * longint'(ms_count / note_period);
            note_bent_f = f < 0 ? 0 : (f > 65535 ? 65535 : int'(f));
        end
        span = note_dur + env_release + env_reverb;
        t.freq = note_bent_f[15:0];
        t.lvl = 7'(blended_level(ms_count));
        t.act = ms_count <= span;
        t.pos = ms_count[adsr_pkg::POS_W-1:0];
        if (ms_count < adsr_pkg::TICK_MAX)
            ms_count++;
        return 1'b1;
    endfunction

    task automatic send_word(input note_word_t w, input bit typed, input tone_word_t want);
        tone_word_t t;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= w.action;
        note_frequency <= w.freq;
        note_duration <= w.dur;
        note_volume <= w.vol;
        bend_step <= w.bend;
        bend_interval <= w.intv;
        do
            @(posedge clk);
        while (in_stall);
        if (play_word(w, t))
            tone_q.push_back(typed ? want : t);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= adsr_pkg::ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            adsr_pkg::REG_ATTACK:  env_attack = val & 16'hFFFF;
            adsr_pkg::REG_DECAY:   env_decay = val & 16'hFFFF;
            adsr_pkg::REG_SUSTAIN: env_sustain = val & 7'h7F;
            adsr_pkg::REG_RELEASE: env_release = val & 16'hFFFF;
            adsr_pkg::REG_REVERB:  env_reverb = val & 16'hFFFF;
            adsr_pkg::REG_NOISE:   env_noise = val & 8'hFF;
            adsr_pkg::REG_DISTORT: env_distort = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic settle();
        wait (tone_q.size() == 0);
        repeat (16) @(posedge clk);
    endtask

    function automatic note_word_t random_note();
        note_word_t w;
        w.action = ACT_START;
        w.freq = 16'($urandom);
        w.dur = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
        w.vol = 7'($urandom_range(127));
        w.bend = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom);
        w.intv = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(8));
        return w;
    endfunction

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != hold_served)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_requests;
        end
        else
            out_stall <= $urandom_range(99) < recv_stall_pct;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (tone_q.size() == 0)
            begin
                report_mismatch("unexpected output word", 1, 0);
            end
            else
            begin
                tone_word_t w;
                w = tone_q.pop_front();
                if (tone_frequency !== w.freq)
                    report_mismatch("tone_frequency", tone_frequency, w.freq);
                if (level !== w.lvl)
                    report_mismatch("level", level, w.lvl);
                if (active !== w.act)
                    report_mismatch("active", active, w.act);
                if (position !== w.pos)
                    report_mismatch("position", position, w.pos);
            end
        end
    end

    initial
    begin
        script_row_t script[$];
        script_row_t r;
        note_word_t w;
        tone_word_t none;
        int ph, sent, ticks;

        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_TICK;
        note_frequency = '0;
        note_duration = '0;
        note_volume = '0;
        bend_step = '0;
        bend_interval = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        none = '0;
        env_attack = 0; env_decay = 0; env_sustain = 100; env_release = 0;
        env_reverb = 0; env_noise = 0; env_distort = 0;
        ms_count = 0; note_start_f = 0; note_bent_f = 0; note_dur = 0;
        note_vol = 100; note_bend = 0; note_period = 0;
        noise_reg = adsr_pkg::LFSR_SEED;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // out of reset: nothing playing, counter at zero then one
        r.typed = 1; r.w = '{ACT_TICK, 16'd0, 16'd0, 7'd0, 16'd0, 16'd0};
        r.want = '{16'd0, 7'd0, 1'b1, 18'd0}; script.push_back(r);
        r.want = '{16'd0, 7'd0, 1'b0, 18'd1}; script.push_back(r);
        // full scale note, volume above hundred held at hundred
        r.w = '{ACT_START, 16'hFFFF, 16'hFFFF, 7'd127, 16'd0, 16'd0};
        r.typed = 0; script.push_back(r);
        r.w = '{ACT_TICK, 16'd0, 16'd0, 7'd0, 16'd0, 16'd0};
        r.typed = 1; r.want = '{16'hFFFF, 7'd100, 1'b1, 18'd0}; script.push_back(r);
        r.typed = 0; script.push_back(r);
        // bend saturating high, then negative bends
        r.w = '{ACT_START, 16'hFFFF, 16'd3, 7'd100, 16'h7FFF, 16'd1}; script.push_back(r);
        r.w = '{ACT_TICK, 16'd0, 16'd0, 7'd0, 16'd0, 16'd0};
        repeat (3) script.push_back(r);
        r.w = '{ACT_START, 16'd0, 16'd2, 7'd0, 16'h8000, 16'hFFFF}; script.push_back(r);
        r.w = '{ACT_TICK, 16'hFFFF, 16'hFFFF, 7'h7F, 16'hFFFF, 16'hFFFF};
        repeat (3) script.push_back(r);
        r.w = '{ACT_START, 16'd1000, 16'd0, 7'd50, 16'hFFFF, 16'd2}; script.push_back(r);
        r.w = '{ACT_TICK, 16'd0, 16'd0, 7'd0, 16'd0, 16'd0};
        repeat (4) script.push_back(r);
        r.w = '{ACT_START, 16'd440, 16'd5, 7'd0, 16'd1, 16'd1}; script.push_back(r);
        r.w = '{ACT_TICK, 16'd0, 16'd0, 7'd0, 16'd0, 16'd0};
        repeat (2) script.push_back(r);

        send_idle_pct = 24;
        recv_stall_pct = 61;
        foreach (script[i])
            send_word(script[i].w, script[i].typed, script[i].want);
        in_valid <= 1'b0;

        for (ph = 0; ph < 6; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    write_reg(adsr_pkg::REG_ATTACK, 3); write_reg(adsr_pkg::REG_DECAY, 4);
                    write_reg(adsr_pkg::REG_SUSTAIN, 60); write_reg(adsr_pkg::REG_RELEASE, 6);
                    write_reg(adsr_pkg::REG_REVERB, 0); write_reg(adsr_pkg::REG_NOISE, 0);
                    write_reg(adsr_pkg::REG_DISTORT, 0);
                end
                1:
                begin
                    write_reg(adsr_pkg::REG_REVERB, 1); write_reg(adsr_pkg::REG_NOISE, 20);
                    write_reg(adsr_pkg::REG_SUSTAIN, 127);
                end
                2:
                begin
                    write_reg(adsr_pkg::REG_ATTACK, 16'hFFFF);
                    write_reg(adsr_pkg::REG_DECAY, 16'hFFFF);
                    write_reg(adsr_pkg::REG_SUSTAIN, 0);
                    write_reg(adsr_pkg::REG_RELEASE, 16'hFFFF);
                    write_reg(adsr_pkg::REG_REVERB, 16'hFFFF);
                    write_reg(adsr_pkg::REG_NOISE, 8'hFF);
                    write_reg(adsr_pkg::REG_DISTORT, 16'hFFFF);
                end
                3:
                begin
                    write_reg(adsr_pkg::REG_ATTACK, $urandom_range(6));
                    write_reg(adsr_pkg::REG_DECAY, $urandom_range(6));
                    write_reg(adsr_pkg::REG_SUSTAIN, $urandom_range(100));
                    write_reg(adsr_pkg::REG_RELEASE, $urandom_range(9));
                    write_reg(adsr_pkg::REG_REVERB, $urandom_range(2, 7));
                    write_reg(adsr_pkg::REG_NOISE, $urandom_range(1, 255));
                    write_reg(adsr_pkg::REG_DISTORT, $urandom_range(1, 4));
                end
                4:
                begin
                    write_reg(adsr_pkg::REG_ATTACK, 0); write_reg(adsr_pkg::REG_DECAY, 0);
                    write_reg(adsr_pkg::REG_SUSTAIN, 100); write_reg(adsr_pkg::REG_RELEASE, 0);
                    write_reg(adsr_pkg::REG_REVERB, 0); write_reg(adsr_pkg::REG_NOISE, 1);
                    write_reg(adsr_pkg::REG_DISTORT, 0);
                end
                default:
                begin
                    write_reg(adsr_pkg::REG_ATTACK, $urandom_range(10));
                    write_reg(adsr_pkg::REG_DECAY, $urandom_range(10));
                    write_reg(adsr_pkg::REG_SUSTAIN, $urandom_range(127));
                    write_reg(adsr_pkg::REG_RELEASE, $urandom_range(12));
                    write_reg(adsr_pkg::REG_REVERB, $urandom_range(1, 9));
                    write_reg(adsr_pkg::REG_NOISE, $urandom_range(255));
                    write_reg(adsr_pkg::REG_DISTORT, $urandom_range(3));
                end
            endcase
            send_idle_pct = ph < 2 ? 24 : (ph < 4 ? 61 : 0);
            recv_stall_pct = ph < 2 ? 61 : (ph < 4 ? 24 : 0);

            sent = 0;
            while (sent < 40)
            begin
                send_word(random_note(), 0, none);
                sent++;
                ticks = $urandom_range(1, 14);
                repeat (ticks)
                begin
                    w = random_note();
                    w.action = ACT_TICK;
                    send_word(w, 0, none);
                    sent++;
                    if (ph == 1 && sent >= 20 && hold_requests == 0)
                        hold_requests++;
                end
                // hold the sender back until every word has drained
                if (ph == 3 && sent > 20 && sent < 40)
                begin
                    in_valid <= 1'b0;
                    wait (tone_q.size() == 0);
                    @(posedge clk);
                end
            end
            in_valid <= 1'b0;
        end

        wait (tone_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && tone_q.size() == 0)
            $display("adsr_voice_envelope_generator test passed");
        else
            $display("adsr_voice_envelope_generator test failed");
        $finish;
    end

endmodule

// ----- adsr_voice_envelope_generator.f -----
sv/adsr_pkg.sv
sv/adsr_ram.sv
sv/adsr_div.sv
sv/adsr_voice_envelope_generator.sv
sv/adsr_checker.sv
bench/adsr_voice_envelope_generator_tb.sv
